### hw/rtl/websocket_frame_deframer_assert.svh
// Assertion macros for the WebSocket frame deframer
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define WSDF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, checked out of reset
`define WSDF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

### hw/rtl/wsdf_pkg.sv
// Types and constants for the WebSocket frame deframer
package wsdf_pkg;

    // parser phase, one-hot
    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_HDR1    = 5'b00010,
        PH_EXTLEN  = 5'b00100,
        PH_KEY     = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } phase_t;

    typedef logic [1:0] status_t;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_CONT  = 2'd1;
    localparam status_t ST_SKIP  = 2'd2;
    localparam status_t ST_ERROR = 2'd3;

    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    localparam logic [7:0] FIN_MASK    = 8'h80;
    localparam logic [7:0] RSV_MASK    = 8'h70;
    localparam logic [7:0] OPCODE_MASK = 8'h0f;
    localparam logic [7:0] MASK_BIT    = 8'h80;
    localparam logic [7:0] LEN_MASK    = 8'h7f;
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    // extended length byte counts, minus one (for a 3-bit counter)
    localparam logic [2:0] EXT16_LAST = 3'd1;
    localparam logic [2:0] EXT64_LAST = 3'd7;
    localparam logic [2:0] KEY_LAST   = 3'd3;

endpackage

### hw/rtl/websocket_frame_deframer.sv
// WebSocket client frame deframer: header parse, key capture and payload unmasking
//
// Takes a client frame one byte per request, with frame_start marking byte 0 (it
// restarts the parser from any phase). Byte 1 gives the mask bit and the 7-bit
// length code; codes 126 and 127 pull in a 2- or 8-byte big-endian length, and then
// four masking key bytes follow. Text and binary frames produce one status request
// after the last key byte (error if unmasked, continuation if FIN is clear, error if
// a reserved bit is set, else ok) carrying the decoded length; ok and continuation
// frames then produce one unmasked payload byte per input byte, the final one with
// last set (a zero-length frame sets last on the status). Ping and pong give a skip
// status after byte 1, close and unknown opcodes an error; bytes are then dropped
// until the next frame_start, as are stray bytes while idle. Throughput is one byte
// per clock unless the output stalls, and each result is registered: each byte is a
// small state update plus an XOR. in_ready drops only while the result register
// holds a request that the consumer has not taken, so a stalled output costs no
// more than that one held request. No parameters; no clearing pass after reset.
module websocket_frame_deframer
    import wsdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        frame_start,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  payload_byte,
    output logic [1:0]  frame_status,
    output logic [63:0] payload_length,
    output logic        last
);

    // parser state
    phase_t      phase_reg, phase_next;
    logic [2:0]  cnt_reg, cnt_next;        // bytes taken in length or key phase
    logic        fin_reg, fin_next;
    logic        rsv_bad_reg, rsv_bad_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        mask_missing_reg, mask_missing_next;
    logic        ext16_reg, ext16_next;    // 16-bit extended length selected
    // holds the decoded length, then counts down the payload bytes still due
    logic [63:0] len_reg, len_next;
    // rotated left one byte per payload byte; top byte is the current key byte
    logic [31:0] key_reg, key_next;

    // result register
    logic        out_valid_reg;
    logic        kind_reg;
    logic [7:0]  pbyte_reg;
    status_t     status_reg;
    logic [63:0] plen_reg;
    logic        last_reg;

    // result of this request
    logic        res_valid;
    logic        res_kind;
    logic [7:0]  res_byte;
    status_t     res_status;
    logic [63:0] res_len;
    logic        res_last;

    logic        step;
    status_t     key_status;
    logic [6:0]  len_code;

    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;
    assign len_code = data_byte[6:0] & LEN_MASK[6:0];

    // status priority: unmasked, then continuation, then reserved bits
    always_comb
    begin
        if (mask_missing_reg)
            key_status = ST_ERROR;
        else if (!fin_reg)
            key_status = ST_CONT;
        else if (rsv_bad_reg)
            key_status = ST_ERROR;
        else
            key_status = ST_OK;
    end

    always_comb
    begin
        phase_next        = phase_reg;
        cnt_next          = cnt_reg;
        fin_next          = fin_reg;
        rsv_bad_next      = rsv_bad_reg;
        opcode_next       = opcode_reg;
        mask_missing_next = mask_missing_reg;
        ext16_next        = ext16_reg;
        len_next          = len_reg;
        key_next          = key_reg;

        res_valid  = 1'b0;
        res_kind   = 1'b1;
        res_byte   = 8'd0;
        res_status = ST_OK;
        res_len    = 64'd0;
        res_last   = 1'b0;

        if (step)
        begin
            if (frame_start)
            begin
                fin_next          = |(data_byte & FIN_MASK);
                rsv_bad_next      = |(data_byte & RSV_MASK);
                opcode_next       = data_byte[3:0] & OPCODE_MASK[3:0];
                mask_missing_next = 1'b0;
                ext16_next        = 1'b0;
                len_next          = 64'd0;
                key_next          = 32'd0;
                cnt_next          = 3'd0;
                phase_next        = PH_HDR1;
            end
            else
            begin
                case (phase_reg)
                    PH_HDR1:
                    begin
                        mask_missing_next = !(|(data_byte & MASK_BIT));
                        cnt_next          = 3'd0;
                        if (opcode_reg == OP_PING || opcode_reg == OP_PONG)
                        begin
                            phase_next = PH_IDLE;
                            res_valid  = 1'b1;
                            res_status = ST_SKIP;
                            res_last   = 1'b1;
                        end
                        else if (opcode_reg != OP_TEXT && opcode_reg != OP_BINARY)
                        begin
                            phase_next = PH_IDLE;
                            res_valid  = 1'b1;
                            res_status = ST_ERROR;
                            res_last   = 1'b1;
                        end
                        else if (len_code == LEN_CODE_16 || len_code == LEN_CODE_64)
                        begin
                            ext16_next = (len_code == LEN_CODE_16);
                            len_next   = 64'd0;
                            phase_next = PH_EXTLEN;
                        end
                        else
                        begin
                            len_next   = {57'd0, len_code};
                            phase_next = PH_KEY;
                        end
                    end

                    PH_EXTLEN:
                    begin
                        len_next = {len_reg[55:0], data_byte};
                        if ((ext16_reg && cnt_reg == EXT16_LAST) || cnt_reg == EXT64_LAST)
                        begin
                            cnt_next   = 3'd0;
                            phase_next = PH_KEY;
                        end
                        else
                        begin
                            cnt_next = cnt_reg + 3'd1;
                        end
                    end

                    PH_KEY:
                    begin
                        key_next = {key_reg[23:0], data_byte};
                        if (cnt_reg == KEY_LAST)
                        begin
                            cnt_next   = 3'd0;
                            res_valid  = 1'b1;
                            res_status = key_status;
                            res_len    = len_reg;
                            if (key_status == ST_ERROR || len_reg == 64'd0)
                            begin
                                res_last   = 1'b1;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                phase_next = PH_PAYLOAD;
                            end
                        end
                        else
                        begin
                            cnt_next = cnt_reg + 3'd1;
                        end
                    end

                    PH_PAYLOAD:
                    begin
                        res_valid = 1'b1;
                        res_kind  = 1'b0;
                        res_byte  = data_byte ^ key_reg[31:24];
                        res_last  = (len_reg == 64'd1);
                        key_next  = {key_reg[23:0], key_reg[31:24]};
                        len_next  = len_reg - 64'd1;
                        if (len_reg == 64'd1)
                            phase_next = PH_IDLE;
                    end

                    default:
                    begin
                        // idle: stray bytes are dropped
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            cnt_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            if (step && res_valid)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // header fields, key, length and result payload
    always_ff @(posedge clk)
    begin
        fin_reg          <= fin_next;
        rsv_bad_reg      <= rsv_bad_next;
        opcode_reg       <= opcode_next;
        mask_missing_reg <= mask_missing_next;
        ext16_reg        <= ext16_next;
        len_reg          <= len_next;
        key_reg          <= key_next;
        if (step && res_valid)
        begin
            kind_reg   <= res_kind;
            pbyte_reg  <= res_byte;
            status_reg <= res_status;
            plen_reg   <= res_len;
            last_reg   <= res_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign payload_byte   = pbyte_reg;
    assign frame_status   = status_reg;
    assign payload_length = plen_reg;
    assign last           = last_reg;

    `include "websocket_frame_deframer_assert.svh"

    // payload requests carry no status or length
    `WSDF_ASSERT_NOW(a_payload_clean, out_valid_reg && !kind_reg, status_reg == ST_OK && plen_reg == 64'd0)
    // a skipped control frame always closes the frame
    `WSDF_ASSERT_NOW(a_skip_last, out_valid_reg && kind_reg && status_reg == ST_SKIP, last_reg)
    // every byte taken mid-payload yields a request
    `WSDF_ASSERT_NEXT(a_payload_result, step && !frame_start && phase_reg == PH_PAYLOAD, out_valid_reg && !kind_reg)
    // frame_start always restarts at the second header byte, with no result
    `WSDF_ASSERT_NEXT(a_start_restart, step && frame_start, phase_reg == PH_HDR1 && cnt_reg == 3'd0)

endmodule

### bench/tb.sv
// Self-checking testbench for the WebSocket frame deframer
module tb;
    import wsdf_pkg::*;

    // One result request: either a frame status or an unmasked payload byte
    typedef struct packed {
        logic        kind;
        logic [7:0]  pbyte;
        status_t     st;
        logic [63:0] plen;
        logic        last;
    } deframe_res_t;

    // How a directed row gets its expectation: from the predictor, none at all,
    // or a status typed straight into the table
    typedef enum logic [1:0] {
        ROW_PRED,
        ROW_NONE,
        ROW_STATUS
    } row_kind_t;

    typedef struct {
        logic [7:0]   b;
        logic         s;
        row_kind_t    rk;
        deframe_res_t r;
    } dir_row_t;

    localparam int unsigned HOLD_CYCLES = 150;
    localparam int unsigned ITEMS_PER_PHASE = 530;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        frame_start = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [1:0]  frame_status;
    logic [63:0] payload_length;
    logic        last;

    // Predictor state, mirrors the parser of the block
    phase_t      ph = PH_IDLE;
    logic [3:0]  hdr_cnt = '0;
    logic        fin_bit = 1'b0;
    logic        rsv_bad = 1'b0;
    logic [3:0]  opc = '0;
    logic [6:0]  len_code = '0;
    logic        unmasked = 1'b0;
    logic [63:0] frame_len = '0;
    logic [31:0] key_word = '0;
    logic [63:0] pay_idx = '0;

    deframe_res_t deframed_q[$];     // results still owed by the block
    int unsigned  n_err = 0;
    int unsigned  n_used = 0;        // bytes the parser acted on (not dropped)
    int unsigned  send_idle = 0;     // percent of cycles the sender holds back
    int unsigned  recv_idle = 0;     // percent of cycles the receiver stalls
    bit           hold_req = 1'b0;   // asks the receiver for one long stall
    int unsigned  st_seen[4] = '{0, 0, 0, 0};
    int unsigned  n_bytes = 0;

    websocket_frame_deframer u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .frame_start    (frame_start),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .payload_byte   (payload_byte),
        .frame_status   (frame_status),
        .payload_length (payload_length),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Generous ceiling: far above the slowest legal run at these stall rates
    initial
    begin
        #6000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        begin
            $display("MISMATCH at %0t: %s", $time, msg);
            n_err++;
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        begin
            if (got !== want)
                report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    // Advance the parser model by one byte. got: a result is produced;
    // used: the byte was not simply dropped.
    task automatic deframe_byte(input logic [7:0] b, input logic s, output bit got,
                                output deframe_res_t r, output bit used);
        status_t     st;
        int unsigned sh;
        begin
            got = 1'b0;
            used = 1'b1;
            r = '0;
            if (s)
            begin
                // frame start restarts the parser from any phase
                fin_bit = (b & FIN_MASK) != 0;
                rsv_bad = (b & RSV_MASK) != 0;
                opc = b[3:0];
                len_code = '0;
                unmasked = 1'b0;
                frame_len = '0;
                key_word = '0;
                pay_idx = '0;
                hdr_cnt = '0;
                ph = PH_HDR1;
            end
            else
            begin
                case (ph)
                    PH_HDR1:
                    begin
                        unmasked = (b & MASK_BIT) == 0;
                        len_code = b[6:0];
                        hdr_cnt = '0;
                        if (opc == OP_PING || opc == OP_PONG)
                        begin
                            ph = PH_IDLE;
                            got = 1'b1;
                            r.kind = 1'b1;
                            r.st = ST_SKIP;
                            r.last = 1'b1;
                        end
                        else if (opc != OP_TEXT && opc != OP_BINARY)
                        begin
                            ph = PH_IDLE;
                            got = 1'b1;
                            r.kind = 1'b1;
                            r.st = ST_ERROR;
                            r.last = 1'b1;
                        end
                        else if (len_code == LEN_CODE_16 || len_code == LEN_CODE_64)
                        begin
                            frame_len = '0;
                            ph = PH_EXTLEN;
                        end
                        else
                        begin
                            frame_len = 64'(len_code);
                            ph = PH_KEY;
                        end
                    end
                    PH_EXTLEN:
                    begin
                        // big-endian, 2 or 8 bytes
                        frame_len = {frame_len[55:0], b};
                        hdr_cnt = hdr_cnt + 4'd1;
                        if (hdr_cnt >= ((len_code == LEN_CODE_16) ? 4'd2 : 4'd8))
                        begin
                            hdr_cnt = '0;
                            ph = PH_KEY;
                        end
                    end
                    PH_KEY:
                    begin
                        key_word = {key_word[23:0], b};
                        hdr_cnt = hdr_cnt + 4'd1;
                        if (hdr_cnt == 4'd4)
                        begin
                            hdr_cnt = '0;
                            // unmasked beats continuation beats reserved bits
                            if (unmasked)
                                st = ST_ERROR;
                            else if (!fin_bit)
                                st = ST_CONT;
                            else if (rsv_bad)
                                st = ST_ERROR;
                            else
                                st = ST_OK;
                            pay_idx = '0;
                            got = 1'b1;
                            r.kind = 1'b1;
                            r.st = st;
                            r.plen = frame_len;
                            if (st == ST_ERROR || frame_len == 0)
                            begin
                                ph = PH_IDLE;
                                r.last = 1'b1;
                            end
                            else
                                ph = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        sh = (3 - int'(pay_idx[1:0])) * 8;
                        r.pbyte = b ^ 8'(key_word >> sh);
                        r.last = (pay_idx == frame_len - 64'd1);
                        got = 1'b1;
                        pay_idx = pay_idx + 64'd1;
                        if (r.last)
                            ph = PH_IDLE;
                    end
                    default:
                    begin
                        // stray byte while idle: dropped
                        ph = PH_IDLE;
                        used = 1'b0;
                    end
                endcase
            end
        end
    endtask

    // Offer one byte, wait for the handshake, then book the expectation
    task automatic push_byte(input logic [7:0] b, input logic s, input row_kind_t rk,
                             input deframe_res_t fixed_r);
        bit           got;
        bit           used;
        deframe_res_t pred;
        begin
            while ($urandom_range(99) < send_idle)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            data_byte <= b;
            frame_start <= s;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            deframe_byte(b, s, got, pred, used);
            if (used)
                n_used++;
            if (rk == ROW_STATUS)
                deframed_q.push_back(fixed_r);
            else if (rk == ROW_PRED && got)
                deframed_q.push_back(pred);
        end
    endtask

    // Mostly well-formed frames with random content; some noise, some cut short
    task automatic send_random_frame();
        int unsigned sel;
        int unsigned n_pay;
        int unsigned cut;
        int unsigned i;
        logic [3:0]  op;
        logic [63:0] flen;
        logic [6:0]  code;
        logic [7:0]  fb[$];
        begin
            sel = $urandom_range(99);
            if (sel < 8)
            begin
                repeat ($urandom_range(1, 6))
                    push_byte(8'($urandom_range(255)), ($urandom_range(7) == 0), ROW_PRED, '0);
            end
            else
            begin
                if (sel < 78)
                    op = $urandom_range(1) ? OP_TEXT : OP_BINARY;
                else if (sel < 88)
                    op = $urandom_range(1) ? OP_PING : OP_PONG;
                else
                    op = 4'($urandom_range(15));
                fb.push_back({($urandom_range(9) != 0),
                              (($urandom_range(9) == 0) ? 3'($urandom_range(1, 7)) : 3'd0),
                              op});
                sel = $urandom_range(99);
                if (sel < 65)
                    flen = 64'($urandom_range(0, 24));
                else if (sel < 75)
                    flen = 64'($urandom_range(0, 125));
                else if (sel < 87)
                    flen = ($urandom_range(3) == 0) ? 64'($urandom_range(0, 65535))
                                                   : 64'($urandom_range(0, 60));
                else
                    flen = ($urandom_range(2) == 0) ? {$urandom, $urandom}
                                                   : 64'($urandom_range(0, 60));
                code = (sel < 75) ? flen[6:0] : (sel < 87) ? LEN_CODE_16 : LEN_CODE_64;
                fb.push_back({($urandom_range(19) != 0), code});
                if (code == LEN_CODE_16)
                begin
                    fb.push_back(flen[15:8]);
                    fb.push_back(flen[7:0]);
                end
                else if (code == LEN_CODE_64)
                begin
                    for (i = 0; i < 8; i++)
                        fb.push_back(flen[8 * (7 - i) +: 8]);
                end
                repeat (4)
                    fb.push_back(8'($urandom_range(255)));
                // huge lengths are cut short and abandoned by the next frame start
                n_pay = (flen <= 64'd48) ? int'(flen) : $urandom_range(0, 24);
                if ($urandom_range(19) == 0)
                    n_pay += $urandom_range(1, 3);
                repeat (n_pay)
                    fb.push_back(8'($urandom_range(255)));
                if ($urandom_range(15) == 0)
                begin
                    cut = $urandom_range(1, fb.size());
                    while (fb.size() > cut)
                        void'(fb.pop_back());
                end
                for (i = 0; i < fb.size(); i++)
                    push_byte(fb[i], (i == 0), ROW_PRED, '0);
            end
        end
    endtask

    function automatic dir_row_t mk_row(logic [7:0] b, logic s, row_kind_t rk, status_t st,
                                        logic [63:0] len, logic lst);
        dir_row_t row;
        row.b = b;
        row.s = s;
        row.rk = rk;
        row.r = '0;
        row.r.kind = 1'b1;
        row.r.st = st;
        row.r.plen = len;
        row.r.last = lst;
        return row;
    endfunction

    // Receiver: random stalls, plus one long hold counted here so the
    // block fills and pushes back on the sender
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Result checker: every accepted request against the oldest expectation
    initial
    begin
        deframe_res_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (deframed_q.size() == 0)
                    report_mismatch($sformatf("unexpected result, kind %0d status %0d",
                                              kind, frame_status));
                else
                begin
                    want = deframed_q.pop_front();
                    check_field("kind", 64'(kind), 64'(want.kind));
                    check_field("payload_byte", 64'(payload_byte), 64'(want.pbyte));
                    check_field("frame_status", 64'(frame_status), 64'(want.st));
                    check_field("payload_length", payload_length, want.plen);
                    check_field("last", 64'(last), 64'(want.last));
                    if (want.kind)
                        st_seen[want.st]++;
                    else
                        n_bytes++;
                end
            end
        end
    end

    initial
    begin
        dir_row_t    tab[$];
        int unsigned k;
        int unsigned target;
        int unsigned send_pct[3];
        int unsigned recv_pct[3];

        send_pct = '{23, 59, 0};
        recv_pct = '{59, 23, 0};
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle = send_pct[0];
        recv_idle = recv_pct[0];

        // stray byte out of reset: dropped
        tab.push_back(mk_row(8'h00, 1'b0, ROW_NONE, ST_OK, 64'd0, 1'b0));
        // ping and pong: skip after byte 1
        tab.push_back(mk_row(8'h89, 1'b1, ROW_NONE, ST_OK, 64'd0, 1'b0));
        tab.push_back(mk_row(8'h80, 1'b0, ROW_STATUS, ST_SKIP, 64'd0, 1'b1));
        tab.push_back(mk_row(8'h8A, 1'b1, ROW_NONE, ST_OK, 64'd0, 1'b0));
        tab.push_back(mk_row(8'h7F, 1'b0, ROW_STATUS, ST_SKIP, 64'd0, 1'b1));
        // close: error after byte 1
        tab.push_back(mk_row(8'h88, 1'b1, ROW_NONE, ST_OK, 64'd0, 1'b0));
        tab.push_back(mk_row(8'hFF, 1'b0, ROW_STATUS, ST_ERROR, 64'd0, 1'b1));
        // all-ones header, abandoned at once by a new frame start
        tab.push_back(mk_row(8'hFF, 1'b1, ROW_NONE, ST_OK, 64'd0, 1'b0));
        // text, FIN clear, 16-bit length of 2: continuation then two bytes
        tab.push_back(mk_row(8'h01, 1'b1, ROW_NONE, ST_OK, 64'd0, 1'b0));
        tab.push_back(mk_row(8'hFE, 1'b0, ROW_NONE, ST_OK, 64'd0, 1'b0));
        tab.push_back(mk_row(8'h00, 1'b0, ROW_NONE, ST_OK, 64'd0, 1'b0));
        tab.push_back(mk_row(8'h02, 1'b0, ROW_NONE, ST_OK, 64'd0, 1'b0));
        tab.push_back(mk_row(8'hFF, 1'b0, ROW_NONE, ST_OK, 64'd0, 1'b0));
        tab.push_back(mk_row(8'h00, 1'b0, ROW_NONE, ST_OK, 64'd0, 1'b0));
        tab.push_back(mk_row(8'hA5, 1'b0, ROW_NONE, ST_OK, 64'd0, 1'b0));
        tab.push_back(mk_row(8'h5A, 1'b0, ROW_STATUS, ST_CONT, 64'd2, 1'b0));
        tab.push_back(mk_row(8'h12, 1'b0, ROW_PRED, ST_OK, 64'd0, 1'b0));
        tab.push_back(mk_row(8'hFF, 1'b0, ROW_PRED, ST_OK, 64'd0, 1'b0));
        // binary with a reserved bit set, zero length: error
        tab.push_back(mk_row(8'hB2, 1'b1, ROW_NONE, ST_OK, 64'd0, 1'b0));
        tab.push_back(mk_row(8'h80, 1'b0, ROW_NONE, ST_OK, 64'd0, 1'b0));
        repeat (3)
            tab.push_back(mk_row(8'h00, 1'b0, ROW_NONE, ST_OK, 64'd0, 1'b0));
        tab.push_back(mk_row(8'h00, 1'b0, ROW_STATUS, ST_ERROR, 64'd0, 1'b1));
        // clean zero-length text: ok with last on the status
        tab.push_back(mk_row(8'h81, 1'b1, ROW_NONE, ST_OK, 64'd0, 1'b0));
        tab.push_back(mk_row(8'h80, 1'b0, ROW_NONE, ST_OK, 64'd0, 1'b0));
        repeat (3)
            tab.push_back(mk_row(8'hC3, 1'b0, ROW_NONE, ST_OK, 64'd0, 1'b0));
        tab.push_back(mk_row(8'h3C, 1'b0, ROW_STATUS, ST_OK, 64'd0, 1'b1));

        for (k = 0; k < tab.size(); k++)
            push_byte(tab[k].b, tab[k].s, tab[k].rk, tab[k].r);

        // three random phases: sender-light, receiver-light, then flat out
        for (k = 0; k < 3; k++)
        begin
            send_idle = send_pct[k];
            recv_idle = recv_pct[k];
            if (k == 2)
                hold_req = 1'b1;
            target = n_used + ITEMS_PER_PHASE;
            while (n_used < target)
                send_random_frame();
        end
        in_valid <= 1'b0;

        while (deframed_q.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);

        $display("Run covered %0d parsed bytes; statuses seen: %0d ok, %0d continuation, %0d skip, %0d error",
                 n_used, st_seen[ST_OK], st_seen[ST_CONT], st_seen[ST_SKIP],
                 st_seen[ST_ERROR]);
        $display("%0d unmasked payload bytes checked under sender and receiver stalls and one long hold",
                 n_bytes);
        if (n_err == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
